>>> hw/rtl/xrg_pkg.sv
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types, constants and the xorshift step for the range generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [WORD_W-1:0] ZERO_FIX    = 32'h9e37_79b9;
    localparam int unsigned       SHIFT_A     = 13;
    localparam int unsigned       SHIFT_B     = 17;
    localparam int unsigned       SHIFT_C     = 5;
    localparam logic [WORD_W-1:0] CHANCE_SPAN = 32'd100;
    localparam logic [WORD_W-1:0] CHANCE_LOW  = 32'd1;

    // register index of the seed
    localparam logic REG_SEED = 1'b0;

    typedef enum logic [1:0] {
        FUNC_RAW    = 2'd0,
        FUNC_RANGE  = 2'd1,
        FUNC_CHANCE = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    // request to the modulo unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_ctrl_t;

    // status from the modulo unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] remainder;
    } div_stat_t;

    // one xorshift step, zero state replaced first
    function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] x;
        x = (s == '0) ? ZERO_FIX : s;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/xrg_mod_unit.sv
// ----------------------------------------------------------------------------
// xrg_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_mod_unit (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire xrg_pkg::div_ctrl_t  ctrl,
    output xrg_pkg::div_stat_t       stat
);
    import xrg_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [WORD_W-1:0] rem_reg, rem_next;

    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              fits;

    // one restoring step
    always_comb begin
        shifted = {rem_reg, dvd_reg[WORD_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    // sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (busy_reg) begin
            rem_next = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = ctrl.dividend;
            dsr_next  = ctrl.divisor;
            rem_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

`ifndef SYNTHESIS
    // a start while idle launches the unit
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start && !busy_reg |=> busy_reg)
        else $error("mod unit did not start");

    // done follows the last busy cycle
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("done without a finished pass");

    // remainder below a nonzero divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && dsr_reg != '0 |-> rem_reg < dsr_reg)
        else $error("remainder not reduced");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/xorshift_range_generator.sv
// ----------------------------------------------------------------------------
// xorshift_range_generator
// Xorshift32 random source serving raw words, ranged draws and percent chances.
// ----------------------------------------------------------------------------
//  channel   ports                          role
//  s_        valid/ready, func, bounds, pct request word in
//  m_        valid/ready, word, value, hit  result word out
//  apb       psel/penable/pwrite/paddr      seed register (index 0)
//
//  raw words, nop, empty or full ranges go from S_IDLE via S_DONE to m_valid
//  modulo draws pass through S_DIV: the shared remainder unit resolves one bit a cycle
//  one request is in flight at a time; s_ready is high only while idle
//  the finished word sits in the output register until m_ready takes it
//  synchronous active-low reset clears the generator state and the seed to zero
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift_range_generator (
    input  wire                                aclk,
    input  wire                                aresetn,
    // request channel
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [1:0]                         s_func,
    input  wire  signed [xrg_pkg::WORD_W-1:0]  s_low_bound,
    input  wire  signed [xrg_pkg::WORD_W-1:0]  s_high_bound,
    input  wire  signed [xrg_pkg::WORD_W-1:0]  s_percent,
    // result channel
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [xrg_pkg::WORD_W-1:0]         m_random_word,
    output logic signed [xrg_pkg::WORD_W-1:0]  m_range_value,
    output logic                               m_chance_hit,
    output logic                               m_advanced,
    // configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [xrg_pkg::ADDR_W-1:0]         paddr,
    input  wire  [xrg_pkg::WORD_W-1:0]         pwdata,
    output logic [xrg_pkg::WORD_W-1:0]         prdata,
    output logic                               pready
);
    import xrg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } fsm_t;

    fsm_t              fsm_reg, fsm_next;
    logic [WORD_W-1:0] gen_reg, gen_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    func_t             func_reg, func_next;
    logic [WORD_W-1:0] low_reg, low_next;
    logic [WORD_W-1:0] pct_reg, pct_next;
    logic [WORD_W-1:0] pend_word_reg, pend_word_next;
    logic [WORD_W-1:0] pend_rv_reg, pend_rv_next;
    logic              pend_adv_reg, pend_adv_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_word_reg, m_word_next;
    logic [WORD_W-1:0] m_rv_reg, m_rv_next;
    logic              m_hit_reg, m_hit_next;
    logic              m_adv_reg, m_adv_next;

    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;

    logic              s_fire;
    logic              cfg_wr;
    logic [WORD_W-1:0] xs_word;
    logic [WORD_W-1:0] span;
    logic              in_empty;

    xrg_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SEED);
    assign prdata = (paddr[ADDR_W-1] == REG_SEED) ? seed_reg : '0;

    // request decode
    assign s_ready  = (fsm_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign xs_word  = xs_step(gen_reg);
    assign span     = s_high_bound - s_low_bound + 1'b1;
    assign in_empty = (s_low_bound >= s_high_bound);

    // sequencer
    always_comb begin
        fsm_next       = fsm_reg;
        gen_next       = gen_reg;
        seed_next      = seed_reg;
        func_next      = func_reg;
        low_next       = low_reg;
        pct_next       = pct_reg;
        pend_word_next = pend_word_reg;
        pend_rv_next   = pend_rv_reg;
        pend_adv_next  = pend_adv_reg;
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        m_rv_next      = m_rv_reg;
        m_hit_next     = m_hit_reg;
        m_adv_next     = m_adv_reg;
        div_ctrl       = '{start: 1'b0, dividend: xs_word, divisor: span};

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (fsm_reg)
            S_IDLE: begin
                if (s_fire) begin
                    func_next      = func_t'(s_func);
                    pct_next       = s_percent;
                    low_next       = s_low_bound;
                    pend_word_next = gen_reg;
                    pend_rv_next   = '0;
                    pend_adv_next  = 1'b0;
                    fsm_next       = S_DONE;
                    unique case (func_t'(s_func))
                        FUNC_RAW: begin
                            gen_next       = xs_word;
                            pend_word_next = xs_word;
                            pend_adv_next  = 1'b1;
                        end
                        FUNC_RANGE: begin
                            if (in_empty) begin
                                pend_rv_next = s_low_bound;
                            end else begin
                                gen_next       = xs_word;
                                pend_word_next = xs_word;
                                pend_adv_next  = 1'b1;
                                if (span == '0) begin
                                    // full 32-bit range wraps
                                    pend_rv_next = s_low_bound + xs_word;
                                end else begin
                                    div_ctrl.start = 1'b1;
                                    fsm_next       = S_DIV;
                                end
                            end
                        end
                        FUNC_CHANCE: begin
                            gen_next         = xs_word;
                            pend_word_next   = xs_word;
                            pend_adv_next    = 1'b1;
                            low_next         = CHANCE_LOW;
                            div_ctrl.start   = 1'b1;
                            div_ctrl.divisor = CHANCE_SPAN;
                            fsm_next         = S_DIV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    pend_rv_next = low_reg + div_stat.remainder;
                    fsm_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = pend_word_reg;
                    m_rv_next    = pend_rv_reg;
                    m_adv_next   = pend_adv_reg;
                    m_hit_next   = (func_reg == FUNC_CHANCE) &&
                                   ($signed(pend_rv_reg) <= $signed(pct_reg));
                    fsm_next     = S_IDLE;
                end
            end
            default: begin
                fsm_next = S_IDLE;
            end
        endcase

        // seed write loads the generator
        if (cfg_wr) begin
            seed_next = pwdata;
            gen_next  = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= S_IDLE;
            gen_reg     <= '0;
            seed_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            gen_reg     <= gen_next;
            seed_reg    <= seed_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg      <= func_next;
        low_reg       <= low_next;
        pct_reg       <= pct_next;
        pend_word_reg <= pend_word_next;
        pend_rv_reg   <= pend_rv_next;
        pend_adv_reg  <= pend_adv_next;
        m_word_reg    <= m_word_next;
        m_rv_reg      <= m_rv_next;
        m_hit_reg     <= m_hit_next;
        m_adv_reg     <= m_adv_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;
    assign m_range_value = m_rv_reg;
    assign m_chance_hit  = m_hit_reg;
    assign m_advanced    = m_adv_reg;

`ifndef SYNTHESIS
    // remainder unit only reports while a draw waits on it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> fsm_reg == S_DIV)
        else $error("remainder done outside a draw");

    // a raw word needs no remainder pass
    a_raw_short: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_func == FUNC_RAW |=> fsm_reg == S_DONE)
        else $error("raw request took the long path");

    // a chance hit is always a stepped draw within 1..100
    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_hit_reg |-> m_adv_reg &&
            $signed(m_rv_reg) >= 1 && $signed(m_rv_reg) <= 100)
        else $error("chance hit out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the xorshift range generator against a cycle-free model of its
// generator state: raw words, signed ranged draws and percent chances, with
// seed loads over the APB port, random stalls on both channels and a final
// stretch of back-to-back traffic.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import xrg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned TAIL_CYCLES = 60;

    localparam logic [ADDR_W-1:0] SEED_ADDR = ADDR_W'(4 * REG_SEED);

    localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] INT_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] ALL_ONE = 32'hffff_ffff;

    // one result word as the block should produce it
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] value;
        logic              hit;
        logic              stepped;
    } draw_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_func = 2'd0;
    logic [WORD_W-1:0] s_low_bound = '0;
    logic [WORD_W-1:0] s_high_bound = '0;
    logic [WORD_W-1:0] s_percent = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [WORD_W-1:0] m_random_word;
    logic [WORD_W-1:0] m_range_value;
    logic              m_chance_hit;
    logic              m_advanced;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [WORD_W-1:0] pwdata = '0;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    draw_result_t      pending_results[$];
    logic [WORD_W-1:0] gen_word = '0;
    logic [WORD_W-1:0] seed_shadow = '0;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       stall_left = 0;
    bit                idle_on = 1'b1;

    xorshift_range_generator u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_low_bound   (s_low_bound),
        .s_high_bound  (s_high_bound),
        .s_percent     (s_percent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word),
        .m_range_value (m_range_value),
        .m_chance_hit  (m_chance_hit),
        .m_advanced    (m_advanced),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each taken result word with the oldest prediction
    always @(posedge aclk) begin : check_results
        draw_result_t head;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding, random_word %h", m_random_word);
                error_count++;
            end else begin
                head = pending_results.pop_front();
                if (m_random_word !== head.word) begin
                    $error("random_word mismatch: expected %h, actual %h",
                           head.word, m_random_word);
                    error_count++;
                end
                if (m_range_value !== head.value) begin
                    $error("range_value mismatch: expected %0d, actual %0d",
                           $signed(head.value), $signed(m_range_value));
                    error_count++;
                end
                if (m_chance_hit !== head.hit) begin
                    $error("chance_hit mismatch: expected %b, actual %b",
                           head.hit, m_chance_hit);
                    error_count++;
                end
                if (m_advanced !== head.stepped) begin
                    $error("advanced mismatch: expected %b, actual %b",
                           head.stepped, m_advanced);
                    error_count++;
                end
            end
        end
    end

    // xorshift 13/17/5 with the zero state patched first
    function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] cur);
        logic [WORD_W-1:0] x;
        x = (cur == '0) ? ZERO_FIX : cur;
        x = x ^ {x[18:0], 13'd0};
        x = x ^ {17'd0, x[31:17]};
        x = x ^ {x[26:0], 5'd0};
        return x;
    endfunction

    // signed inclusive range draw, steps the generator unless the range is empty
    function automatic void draw_in_range(input logic [WORD_W-1:0] lo,
                                          input logic [WORD_W-1:0] hi,
                                          output logic [WORD_W-1:0] value,
                                          output logic stepped);
        logic [WORD_W-1:0] span;
        if ($signed(lo) >= $signed(hi)) begin
            value   = lo;
            stepped = 1'b0;
        end else begin
            span     = hi - lo + 32'd1;
            gen_word = xorshift_next(gen_word);
            stepped  = 1'b1;
            // full 32-bit range wraps the span to zero
            value = (span == '0) ? lo + gen_word : lo + (gen_word % span);
        end
    endfunction

    // expected result of one accepted request word
    function automatic void predict_request(input func_t f,
                                            input logic [WORD_W-1:0] lo,
                                            input logic [WORD_W-1:0] hi,
                                            input logic [WORD_W-1:0] pct);
        draw_result_t r;
        r = '0;
        case (f)
            FUNC_RAW: begin
                gen_word  = xorshift_next(gen_word);
                r.stepped = 1'b1;
            end
            FUNC_RANGE: begin
                draw_in_range(lo, hi, r.value, r.stepped);
            end
            FUNC_CHANCE: begin
                draw_in_range(CHANCE_LOW, CHANCE_SPAN, r.value, r.stepped);
                r.hit = ($signed(r.value) <= $signed(pct));
            end
            default: begin
            end
        endcase
        r.word = gen_word;
        pending_results.push_back(r);
    endfunction

    // one request word, with an optional gap in front
    task automatic send_request(input func_t f, input logic [WORD_W-1:0] lo,
                                input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] pct);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_low_bound  <= lo;
        s_high_bound <= hi;
        s_percent    <= pct;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(f, lo, hi, pct);
    endtask

    // stop sending and let every outstanding result drain
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [WORD_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_seed_readback();
        logic [WORD_W-1:0] rd;
        apb_read(SEED_ADDR, rd);
        if (rd !== seed_shadow) begin
            $error("seed_value mismatch: expected %h, actual %h", seed_shadow, rd);
            error_count++;
        end
    endtask

    // seed write also reloads the generator state
    task automatic load_seed(input logic [WORD_W-1:0] value);
        apb_write(SEED_ADDR, value);
        seed_shadow = value;
        gen_word    = value;
        check_seed_readback();
    endtask

    // random request, mostly well-formed draws with a spread of range shapes
    task automatic send_random_request();
        int unsigned       pick;
        func_t             f;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] pct;
        pick = $urandom_range(0, 99);
        lo   = $urandom;
        hi   = $urandom;
        pct  = $urandom;
        if (pick < 20) begin
            f = FUNC_RAW;
        end else if (pick < 60) begin
            f = FUNC_RANGE;
            case ($urandom_range(0, 5))
                0: begin
                end
                1: hi = lo + $urandom_range(1, 1000);
                2: begin
                    lo = INT_MIN;
                    hi = INT_MAX;
                end
                3: hi = lo - $urandom_range(0, 5);
                4: begin
                    lo = $urandom_range(0, 100) - 50;
                    hi = lo + $urandom_range(0, 60);
                end
                default: begin
                    lo = lo | INT_MIN;
                    hi = hi & INT_MAX;
                end
            endcase
        end else if (pick < 92) begin
            f = FUNC_CHANCE;
            case ($urandom_range(0, 4))
                0: begin
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: pct = INT_MIN;
                        1: pct = INT_MAX;
                        2: pct = '0;
                        default: pct = CHANCE_SPAN;
                    endcase
                end
                default: pct = $urandom_range(0, 110) - 5;
            endcase
        end else begin
            f = FUNC_NOP;
        end
        send_request(f, lo, hi, pct);
    endtask

    // state straight out of reset: zero word, then the zero patch on first step
    task automatic test_reset_state();
        check_seed_readback();
        send_request(FUNC_NOP, '0, '0, '0);
        send_request(FUNC_RANGE, 32'd5, 32'd5, '0);
        send_request(FUNC_RANGE, INT_MAX, INT_MIN, '0);
        send_request(FUNC_RAW, '0, '0, '0);
    endtask

    // range edges, full range and chance thresholds
    task automatic test_directed_edges();
        send_request(FUNC_RANGE, INT_MIN, INT_MAX, '0);
        send_request(FUNC_RANGE, INT_MIN, '0, '0);
        send_request(FUNC_RANGE, ALL_ONE, '0, '0);
        send_request(FUNC_RANGE, INT_MIN, INT_MIN + 32'd1, '0);
        send_request(FUNC_RANGE, INT_MAX - 32'd1, INT_MAX, '0);
        send_request(FUNC_RANGE, '0, INT_MAX, '0);
        send_request(FUNC_CHANCE, '0, '0, INT_MIN);
        send_request(FUNC_CHANCE, '0, '0, ALL_ONE);
        send_request(FUNC_CHANCE, '0, '0, '0);
        send_request(FUNC_CHANCE, '0, '0, 32'd1);
        send_request(FUNC_CHANCE, '0, '0, 32'd50);
        send_request(FUNC_CHANCE, '0, '0, CHANCE_SPAN);
        send_request(FUNC_CHANCE, '0, '0, 32'd101);
        send_request(FUNC_CHANCE, '0, '0, INT_MAX);
        send_request(FUNC_NOP, ALL_ONE, ALL_ONE, ALL_ONE);
        send_request(FUNC_RAW, ALL_ONE, ALL_ONE, ALL_ONE);
    endtask

    // a few requests after each of a set of seeds
    task automatic test_seed_loads();
        logic [WORD_W-1:0] seeds[6];
        seeds = '{32'd0, ALL_ONE, 32'd1, INT_MIN, ZERO_FIX, 32'h0};
        seeds[5] = $urandom;
        foreach (seeds[i]) begin
            wait_results_done();
            load_seed(seeds[i]);
            send_request(FUNC_NOP, '0, '0, '0);
            send_request(FUNC_RAW, '0, '0, '0);
            send_request(FUNC_RANGE, 32'hffff_fff6, 32'd10, '0);
            send_request(FUNC_CHANCE, '0, '0, 32'd50);
        end
    endtask

    // long random traffic with stalls, reseeded per phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            wait_results_done();
            case (phase)
                1: load_seed(ALL_ONE);
                2: load_seed('0);
                default: load_seed($urandom);
            endcase
            for (int n = 0; n < 250; n++) send_random_request();
        end
    endtask

    // back-to-back words with no idling on either side
    task automatic test_streaming();
        wait_results_done();
        idle_on = 1'b0;
        load_seed($urandom);
        for (int n = 0; n < 100; n++) send_random_request();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_directed_edges();
        test_seed_loads();
        test_random_traffic();
        test_streaming();
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/xrg_pkg.sv
hw/rtl/xrg_mod_unit.sv
hw/rtl/xorshift_range_generator.sv
tb/sv/testbench.sv
